// File: design/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/uvp_pkg.sv
// types and constants of the utf-8 path validator
`default_nettype none
package uvp_pkg;

  localparam logic [7:0] ChSlash     = 8'h2f;
  localparam logic [7:0] ChDot       = 8'h2e;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChDel       = 8'h7f;
  localparam logic [7:0] ChSpace     = 8'h20;

  localparam logic [20:0] CodeMax = 21'h10ffff;
  localparam logic [20:0] SurrLo  = 21'h00d800;
  localparam logic [20:0] SurrHi  = 21'h00dfff;
  localparam logic [20:0] Min2    = 21'h000080;
  localparam logic [20:0] Min3    = 21'h000800;
  localparam logic [20:0] Min4    = 21'h010000;

  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  localparam logic [12:0] PathCeil = 13'd4096;
  localparam logic [8:0]  PartCeil = 9'd256;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 12;
  localparam logic [CfgAddrW-1:0] RegMaxPath = 2'd0;
  localparam logic [CfgAddrW-1:0] RegMaxComp = 2'd1;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_INVALID
  } byte_class_e;

  typedef enum logic [1:0] {
    DOT_NONE,
    DOT_ONE,
    DOT_TWO,
    DOT_OTHER
  } dot_state_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last;
    logic        bare_root;
    logic        component_only;
    byte_class_e cls;
    logic        is_slash;
    logic        is_dot;
    logic        is_bad_char;
  } uvp_item_t;

  typedef struct packed {
    logic [11:0] max_path_bytes;
    logic [7:0]  max_component_bytes;
  } uvp_cfg_t;

endpackage
`default_nettype wire

// File: design/uvp_front.sv
// front end: takes input transfers and classifies each byte
`default_nettype none
module uvp_front
  import uvp_pkg::*;
(
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       has_byte_i,
  input  wire logic       last_i,
  input  wire logic       bare_root_i,
  input  wire logic       component_only_i,
  output logic            push_valid_o,
  input  wire logic       push_ready_i,
  output uvp_item_t       push_item_o
);

  byte_class_e cls;

  always_comb begin
    if (data_byte_i <= 8'h7f) begin
      cls = CLS_ASCII;
    end else if (data_byte_i <= 8'hbf) begin
      cls = CLS_CONT;
    end else if (data_byte_i >= 8'hc2 && data_byte_i <= 8'hdf) begin
      cls = CLS_LEAD2;
    end else if (data_byte_i >= 8'he0 && data_byte_i <= 8'hef) begin
      cls = CLS_LEAD3;
    end else if (data_byte_i >= 8'hf0 && data_byte_i <= 8'hf4) begin
      cls = CLS_LEAD4;
    end else begin
      cls = CLS_INVALID;
    end
  end

  always_comb begin
    push_item_o.data_byte      = data_byte_i;
    push_item_o.has_byte       = has_byte_i;
    push_item_o.last           = last_i;
    push_item_o.bare_root      = bare_root_i;
    push_item_o.component_only = component_only_i;
    push_item_o.cls            = cls;
    push_item_o.is_slash       = (data_byte_i == ChSlash);
    push_item_o.is_dot         = (data_byte_i == ChDot);
    push_item_o.is_bad_char    = (data_byte_i < ChSpace) || (data_byte_i == ChDel) ||
                                 (data_byte_i == ChBackslash);
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule
`default_nettype wire

// File: design/uvp_queue.sv
// short queue between front and back end
`default_nettype none
`include "assert_macros.svh"
module uvp_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [Width-1:0]      pop_data_o
);

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  logic [Width-1:0]  mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CountW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ASSERT_ALWAYS(count_in_range_a, clk_i, rst_ni, count_q <= CountW'(Depth))
  `ASSERT_NEXT(full_after_fill_a, clk_i, rst_ni,
    push && !pop && count_q == CountW'(Depth - 1), !push_ready_o)
  `ASSERT_NEXT(valid_after_push_a, clk_i, rst_ni, push, pop_valid_o)

endmodule
`default_nettype wire

// File: design/uvp_back.sv
// back end: string state, rule checks and result register
`default_nettype none
`include "assert_macros.svh"
module uvp_back
  import uvp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire uvp_cfg_t  cfg_i,
  input  wire logic      pop_valid_i,
  output logic           pop_ready_o,
  input  wire uvp_item_t pop_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output logic           string_ok_o,
  output logic [12:0]    bytes_seen_o
);

  logic [1:0]  seq_rem_q, seq_rem_d;
  logic [2:0]  seq_len_q, seq_len_d;
  logic [20:0] partial_q, partial_d;
  logic [12:0] total_q, total_d;
  logic [8:0]  part_q, part_d;
  dot_state_e  dot_q, dot_d;
  logic        prev_slash_q, prev_slash_d;
  logic        failed_q, failed_d;
  logic [1:0]  modes_q, modes_d;

  logic        out_valid_q;
  logic        ok_q, ok_d;
  logic [12:0] seen_q;

  logic        take, first, comp_mode, verdict;
  logic [20:0] code;

  // a string end needs the result slot, other transfers never wait
  assign pop_ready_o = !pop_item_i.last || !out_valid_q || out_ready_i;
  assign take        = pop_valid_i && pop_ready_o;

  always_comb begin
    seq_rem_d    = seq_rem_q;
    seq_len_d    = seq_len_q;
    partial_d    = partial_q;
    total_d      = total_q;
    part_d       = part_q;
    dot_d        = dot_q;
    prev_slash_d = prev_slash_q;
    failed_d     = failed_q;
    modes_d      = modes_q;
    verdict      = 1'b0;
    code         = {partial_q[14:0], pop_item_i.data_byte[5:0]};

    first = (total_q == '0);
    if (first) begin
      modes_d = {pop_item_i.component_only, pop_item_i.bare_root};
    end
    comp_mode = modes_d[1];

    if (pop_item_i.has_byte) begin
      // utf-8 sequence tracking
      if (seq_rem_q == '0) begin
        unique case (pop_item_i.cls)
          CLS_ASCII: begin
          end
          CLS_LEAD2: begin
            seq_len_d = SeqLen2;
            seq_rem_d = 2'd1;
            partial_d = {16'd0, pop_item_i.data_byte[4:0]};
          end
          CLS_LEAD3: begin
            seq_len_d = SeqLen3;
            seq_rem_d = 2'd2;
            partial_d = {17'd0, pop_item_i.data_byte[3:0]};
          end
          CLS_LEAD4: begin
            seq_len_d = SeqLen4;
            seq_rem_d = 2'd3;
            partial_d = {18'd0, pop_item_i.data_byte[2:0]};
          end
          default: begin
            failed_d = 1'b1;
          end
        endcase
      end else if (pop_item_i.cls != CLS_CONT) begin
        failed_d  = 1'b1;
        seq_rem_d = '0;
        seq_len_d = '0;
        partial_d = '0;
      end else begin
        partial_d = code;
        seq_rem_d = seq_rem_q - 1'b1;
        if (seq_rem_q == 2'd1) begin
          // sequence complete: overlong, range and surrogate checks
          if ((seq_len_q == SeqLen2 && code < Min2) ||
              (seq_len_q == SeqLen3 && code < Min3) ||
              (seq_len_q == SeqLen4 && code < Min4) ||
              code > CodeMax || (code >= SurrLo && code <= SurrHi)) begin
            failed_d = 1'b1;
          end
          seq_len_d = '0;
          partial_d = '0;
        end
      end

      // path component rules
      if (pop_item_i.is_slash) begin
        if (comp_mode) begin
          failed_d = 1'b1;
        end else if (!first && (prev_slash_q || dot_q == DOT_ONE || dot_q == DOT_TWO)) begin
          failed_d = 1'b1;
        end
        part_d       = '0;
        dot_d        = DOT_NONE;
        prev_slash_d = 1'b1;
      end else begin
        if (first && !comp_mode) begin
          failed_d = 1'b1;
        end
        if (pop_item_i.is_bad_char) begin
          failed_d = 1'b1;
        end
        if (part_q < PartCeil) begin
          part_d = part_q + 1'b1;
        end
        if (part_d > {1'b0, cfg_i.max_component_bytes}) begin
          failed_d = 1'b1;
        end
        if (pop_item_i.is_dot) begin
          unique case (dot_q)
            DOT_NONE: dot_d = DOT_ONE;
            DOT_ONE:  dot_d = DOT_TWO;
            default:  dot_d = DOT_OTHER;
          endcase
        end else begin
          dot_d = DOT_OTHER;
        end
        prev_slash_d = 1'b0;
      end

      if (total_q < PathCeil) begin
        total_d = total_q + 1'b1;
      end
      if (!comp_mode && total_d > {1'b0, cfg_i.max_path_bytes}) begin
        failed_d = 1'b1;
      end
    end

    // verdict on the updated state
    priority if (failed_d || seq_rem_d != '0 || total_d == '0) begin
      verdict = 1'b0;
    end else if (!comp_mode && total_d == 13'd1 && prev_slash_d) begin
      verdict = modes_d[0];
    end else if (!comp_mode && prev_slash_d) begin
      verdict = 1'b0;
    end else if (dot_d == DOT_ONE || dot_d == DOT_TWO) begin
      verdict = 1'b0;
    end else begin
      verdict = 1'b1;
    end
    ok_d = verdict;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_rem_q    <= '0;
      seq_len_q    <= '0;
      partial_q    <= '0;
      total_q      <= '0;
      part_q       <= '0;
      dot_q        <= DOT_NONE;
      prev_slash_q <= 1'b0;
      failed_q     <= 1'b0;
      modes_q      <= '0;
    end else if (take) begin
      if (pop_item_i.last) begin
        seq_rem_q    <= '0;
        seq_len_q    <= '0;
        partial_q    <= '0;
        total_q      <= '0;
        part_q       <= '0;
        dot_q        <= DOT_NONE;
        prev_slash_q <= 1'b0;
        failed_q     <= 1'b0;
        modes_q      <= '0;
      end else begin
        seq_rem_q    <= seq_rem_d;
        seq_len_q    <= seq_len_d;
        partial_q    <= partial_d;
        total_q      <= total_d;
        part_q       <= part_d;
        dot_q        <= dot_d;
        prev_slash_q <= prev_slash_d;
        failed_q     <= failed_d;
        modes_q      <= modes_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && pop_item_i.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && pop_item_i.last) begin
      ok_q   <= ok_d;
      seen_q <= total_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign string_ok_o  = ok_q;
  assign bytes_seen_o = seen_q;

  `ASSERT_ALWAYS(seq_len_matches_a, clk_i, rst_ni,
    seq_rem_q == '0 || ({1'b0, seq_rem_q} < seq_len_q))
  `ASSERT_ALWAYS(empty_string_clean_a, clk_i, rst_ni,
    total_q != '0 || (!failed_q && part_q == '0 && seq_rem_q == '0))
  `ASSERT_ALWAYS(ok_has_bytes_a, clk_i, rst_ni,
    !(out_valid_q && ok_q) || seen_q != '0)

endmodule
`default_nettype wire

// File: design/utf8_path_validator.sv
// utf-8 path validator top level: config registers, front end, queue, back end
// a string end transfer passes through the queue and then the result register
// before out_valid_o rises; throughput: one byte per cycle, set by the per-byte
// state update, while the queue has room and no string end awaits the result slot
// reset clears all string state and the queue; limits return to 1023 and 255
// config writes are taken every cycle and change the limits at once
`default_nettype none
module utf8_path_validator
  import uvp_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // byte input channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                has_byte_i,
  input  wire logic                last_i,
  input  wire logic                bare_root_i,
  input  wire logic                component_only_i,
  // verdict channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     string_ok_o,
  output logic [12:0]              bytes_seen_o
);

  localparam int unsigned ItemW = $bits(uvp_item_t);

  uvp_cfg_t  cfg_q;
  uvp_item_t push_item, pop_item;
  logic      push_valid, push_ready, pop_valid, pop_ready;

  // limits accept a write every cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_path_bytes      <= 12'd1023;
      cfg_q.max_component_bytes <= 8'd255;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        RegMaxPath: cfg_q.max_path_bytes      <= cfg_data_i;
        RegMaxComp: cfg_q.max_component_bytes <= cfg_data_i[7:0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // front end: byte classes and flags computed at the input transfer
  uvp_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .last_i           (last_i),
    .bare_root_i      (bare_root_i),
    .component_only_i (component_only_i),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_item_o      (push_item)
  );

  // queue decouples input stalls from result stalls
  uvp_queue #(
    .Width (ItemW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_item)
  );

  // back end: per-string state and verdict register
  uvp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_item_i   (pop_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .string_ok_o  (string_ok_o),
    .bytes_seen_o (bytes_seen_o)
  );

endmodule
`default_nettype wire
